### rtl/core/mccw_pkg.sv
package mccw_pkg;

  // Table geometry: one row per source state, one column per destination state
  localparam int unsigned MAX_STATES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_STATES);
  localparam int unsigned ADDR_W     = 2 * IDX_W;
  localparam int unsigned NUM_W      = IDX_W + 1;

  // Cost formats: entry Q16.16, total and limit Q32.16
  localparam int unsigned ECOST_W = 32;
  localparam int unsigned COST_W  = 48;
  localparam int unsigned ALU_W   = COST_W + 1;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;
  localparam logic        REG_NUM_STATES = 1'b0;
  localparam logic        REG_COST_BOUND = 1'b1;

  localparam logic [NUM_W-1:0] NUM_STATES_RST = NUM_W'(MAX_STATES);
  localparam logic [NUM_W-1:0] NUM_STATES_MIN = NUM_W'(2);
  localparam logic [NUM_W-1:0] NUM_STATES_MAX = NUM_W'(MAX_STATES);

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage

### rtl/core/markov_chain_cost_walker_core.sv
// Markov chain walker with per-transition costs.
//
// Input channel (in_valid_i / in_stall_o) carries one word per operation:
// load a table entry, take one step with a random fraction, or restart the
// walk. The output channel (out_valid_o / out_stall_i) returns one status
// word per input word: current state, saturating cost total, finished flag,
// within-limit flag and whether a transition was taken.
// Load, restart, unused codes and a step from the last state go straight
// to the limit compare. Any other step scans its row, up to MAX_STATES
// entries: the table memory delivers one entry per cycle to the shared
// adder, which forms the running probability sum, then the cost sum, then
// the limit compare. One word is in flight at a time; the next is taken
// the cycle after the result is handed to the output register.
// After reset the table is swept to zero, one entry per cycle, while
// in_stall_o stays high; configuration writes are taken throughout.
// A stalled result waits in the output register; the block holds its last
// stage until that register frees up.
module markov_chain_cost_walker_core #(
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mccw_pkg::PADDR_W-1:0]         paddr,
  input  logic [mccw_pkg::PDATA_W-1:0]         pwdata,
  output logic [mccw_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           func_i,
  input  logic [mccw_pkg::IDX_W-1:0]           row_index_i,
  input  logic [mccw_pkg::IDX_W-1:0]           col_index_i,
  input  logic [PROB_FRAC_BITS:0]              entry_prob_i,
  input  logic signed [mccw_pkg::ECOST_W-1:0]  entry_cost_i,
  input  logic [PROB_FRAC_BITS-1:0]            rand_frac_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mccw_pkg::IDX_W-1:0]           state_now_o,
  output logic signed [mccw_pkg::COST_W-1:0]   cost_sum_o,
  output logic                                 finished_o,
  output logic                                 within_limit_o,
  output logic                                 moved_o
);
  import mccw_pkg::*;

  localparam int unsigned PROB_W = PROB_FRAC_BITS + 1;
  // Sum of MAX_STATES probabilities can never wrap at this width
  localparam int unsigned SUM_W  = PROB_W + IDX_W;
  localparam int unsigned FRAC_W = PROB_FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_ADD   = 5'b01000,
    S_LIMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [NUM_W-1:0]         num_states_q;
  logic signed [COST_W-1:0] cost_bound_q;
  logic                     cfg_wr;
  logic                     reg_idx;

  // walk state
  logic [IDX_W-1:0]         walk_q, walk_d;
  logic signed [COST_W-1:0] cost_q, cost_d;
  logic                     moved_q, moved_d;

  // scan datapath
  logic [IDX_W-1:0]          rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]          cmp_idx_q, cmp_idx_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [FRAC_W-1:0]         rand_q, rand_d;
  logic [IDX_W-1:0]          hit_col_q, hit_col_d;
  logic signed [ECOST_W-1:0] hit_cost_q, hit_cost_d;

  // output register
  logic                     out_vld_q, out_vld_d;
  logic                     out_load;
  logic [IDX_W-1:0]         out_state_q;
  logic signed [COST_W-1:0] out_cost_q;
  logic                     out_fin_q;
  logic                     out_within_q;
  logic                     out_moved_q;

  // table
  logic                      tbl_wr_en;
  logic                      tbl_busy;
  logic [PROB_W-1:0]         tbl_prob;
  logic signed [ECOST_W-1:0] tbl_cost;

  // shared adder
  alu_op_e                   alu_op;
  logic signed [ALU_W-1:0]   alu_a, alu_b, alu_res;

  logic                      in_acc;
  logic [NUM_W-1:0]          n_use;
  logic [NUM_W-1:0]          last_st;
  logic                      at_end;
  logic [SUM_W-1:0]          rand_ext;
  logic [SUM_W-1:0]          sum_next;
  logic                      hit;
  logic signed [COST_W-1:0]  cost_sat;
  logic                      in_bound;

  // ---------------------------------------------------------------------
  // Configuration port: always ready, index by 8-byte slot
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_NUM_STATES: prdata = {{(PDATA_W-NUM_W){1'b0}}, num_states_q};
      REG_COST_BOUND: prdata = {{(PDATA_W-COST_W){cost_bound_q[COST_W-1]}}, cost_bound_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= NUM_STATES_RST;
      cost_bound_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NUM_STATES: num_states_q <= pwdata[NUM_W-1:0];
        REG_COST_BOUND: cost_bound_q <= pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the state count into the supported range
  always_comb begin
    if (num_states_q < NUM_STATES_MIN) begin
      n_use = NUM_STATES_MIN;
    end else if (num_states_q > NUM_STATES_MAX) begin
      n_use = NUM_STATES_MAX;
    end else begin
      n_use = num_states_q;
    end
  end

  assign last_st = n_use - 1'b1;
  assign at_end  = {1'b0, walk_q} >= last_st;

  // ---------------------------------------------------------------------
  // Transition table
  // ---------------------------------------------------------------------
  mccw_table #(
    .PROB_W (PROB_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i ({row_index_i, col_index_i}),
    .wr_prob_i (entry_prob_i),
    .wr_cost_i (entry_cost_i),
    .rd_addr_i ({walk_q, rd_idx_q}),
    .rd_prob_o (tbl_prob),
    .rd_cost_o (tbl_cost),
    .busy_o    (tbl_busy)
  );

  // ---------------------------------------------------------------------
  // Shared adder: probability sum while scanning, cost sum on a move,
  // limit minus cost otherwise
  // ---------------------------------------------------------------------
  always_comb begin
    case (state_q)
      S_SCAN: begin
        alu_op = ALU_ADD;
        alu_a  = {{(ALU_W-SUM_W){1'b0}}, sum_q};
        alu_b  = {{(ALU_W-PROB_W){1'b0}}, tbl_prob};
      end
      S_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = {cost_q[COST_W-1], cost_q};
        alu_b  = {{(ALU_W-ECOST_W){hit_cost_q[ECOST_W-1]}}, hit_cost_q};
      end
      default: begin
        alu_op = ALU_SUB;
        alu_a  = {cost_bound_q[COST_W-1], cost_bound_q};
        alu_b  = {cost_q[COST_W-1], cost_q};
      end
    endcase
  end

  mccw_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign sum_next = alu_res[SUM_W-1:0];
  assign rand_ext = {{(SUM_W-FRAC_W){1'b0}}, rand_q};
  // First non-empty interval [sum, sum + p) that holds the fraction
  assign hit      = (tbl_prob != '0) && (rand_ext >= sum_q) && (rand_ext < sum_next);
  assign in_bound = !alu_res[ALU_W-1];

  // Clip the cost sum at the signed limits
  always_comb begin
    if (alu_res[ALU_W-1] != alu_res[ALU_W-2]) begin
      cost_sat = alu_res[ALU_W-1] ? COST_MIN : COST_MAX;
    end else begin
      cost_sat = alu_res[COST_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE) || tbl_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_LIMIT) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    cost_d     = cost_q;
    moved_d    = moved_q;
    rd_idx_d   = rd_idx_q;
    cmp_idx_d  = cmp_idx_q;
    sum_d      = sum_q;
    rand_d     = rand_q;
    hit_col_d  = hit_col_q;
    hit_cost_d = hit_cost_q;
    tbl_wr_en  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          moved_d = 1'b0;
          rand_d  = rand_frac_i;
          state_d = S_LIMIT;
          case (func_e'(func_i))
            FUNC_LOAD: begin
              tbl_wr_en = 1'b1;
            end
            FUNC_STEP: begin
              // absorbing state: report without moving
              if (!at_end) begin
                rd_idx_d = '0;
                sum_d    = '0;
                state_d  = S_FETCH;
              end
            end
            FUNC_RESTART: begin
              walk_d = '0;
              cost_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        // first read of the row is in flight
        cmp_idx_d = rd_idx_q;
        rd_idx_d  = rd_idx_q + 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          hit_col_d  = cmp_idx_q;
          hit_cost_d = tbl_cost;
          state_d    = S_ADD;
        end else begin
          sum_d = sum_next;
          if ({1'b0, cmp_idx_q} == last_st) begin
            state_d = S_LIMIT;
          end else begin
            cmp_idx_d = rd_idx_q;
            rd_idx_d  = rd_idx_q + 1'b1;
          end
        end
      end
      S_ADD: begin
        cost_d  = cost_sat;
        walk_d  = hit_col_q;
        moved_d = 1'b1;
        state_d = S_LIMIT;
      end
      S_LIMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      walk_q    <= '0;
      cost_q    <= '0;
      moved_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      cost_q    <= cost_d;
      moved_q   <= moved_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    sum_q      <= sum_d;
    rand_q     <= rand_d;
    hit_col_q  <= hit_col_d;
    hit_cost_q <= hit_cost_d;
    if (out_load) begin
      out_state_q  <= walk_q;
      out_cost_q   <= cost_q;
      out_fin_q    <= at_end;
      out_within_q <= in_bound;
      out_moved_q  <= moved_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign state_now_o    = out_state_q;
  assign cost_sum_o     = out_cost_q;
  assign finished_o     = out_fin_q;
  assign within_limit_o = out_within_q;
  assign moved_o        = out_moved_q;

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_busy |-> in_stall_o)
    else $error("word accepted during table clear");

  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, cmp_idx_q} <= last_st))
    else $error("scan ran past the last state in use");

  a_scan_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rand_ext >= sum_q))
    else $error("running sum passed the fraction without a hit");

  a_add_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |=> (moved_q && (state_q == S_LIMIT)))
    else $error("cost update did not record a move");
`endif

endmodule

### rtl/core/mccw_alu.sv
module mccw_alu (
  input  mccw_pkg::alu_op_e                  op_i,
  input  logic signed [mccw_pkg::ALU_W-1:0]  a_i,
  input  logic signed [mccw_pkg::ALU_W-1:0]  b_i,
  output logic signed [mccw_pkg::ALU_W-1:0]  res_o
);
  import mccw_pkg::*;

  always_comb begin
    case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_SUB: res_o = a_i - b_i;
      default: res_o = a_i + b_i;
    endcase
  end

endmodule

### rtl/core/mccw_table.sv
module mccw_table #(
  parameter int unsigned PROB_W = 17
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [mccw_pkg::ADDR_W-1:0]           wr_addr_i,
  input  logic [PROB_W-1:0]                     wr_prob_i,
  input  logic signed [mccw_pkg::ECOST_W-1:0]   wr_cost_i,
  input  logic [mccw_pkg::ADDR_W-1:0]           rd_addr_i,
  output logic [PROB_W-1:0]                     rd_prob_o,
  output logic signed [mccw_pkg::ECOST_W-1:0]   rd_cost_o,
  output logic                                  busy_o
);
  import mccw_pkg::*;

  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned DATA_W = PROB_W + ECOST_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_q;
  logic              busy_q;

  // Sweep every entry to zero after reset, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == {ADDR_W{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_prob_i, wr_cost_i};
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  assign rd_prob_o = rdata_q[DATA_W-1:ECOST_W];
  assign rd_cost_o = rdata_q[ECOST_W-1:0];
  assign busy_o    = busy_q;

`ifndef SYNTHESIS
  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(clr_q) == {ADDR_W{1'b1}})
    else $error("table clear ended before the last entry");
`endif

endmodule
